// ===== design/mesh_shear_sort_assert.svh =====
// Assertion macros used by the shearsort sequencer RTL.
`ifndef MESH_SHEAR_SORT_ASSERT_SVH
`define MESH_SHEAR_SORT_ASSERT_SVH

// Property must hold at every rising clock edge outside reset.
`define MSS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Condition must never be true outside reset.
`define MSS_NEVER(lbl, cond, msg) \
   `MSS_ASSERT(lbl, !(cond), msg)

`endif

// ===== design/mss_pkg.sv =====
// Package: sizes, types and helpers for the shearsort mesh.
`default_nettype none
package mss_pkg;
   localparam int MAX_SIDE    = 8;
   localparam int VALUE_WIDTH = 32;
   localparam int CFG_W       = 4;
   localparam int MAX_CELLS   = MAX_SIDE * MAX_SIDE;
   localparam int SIDE_W      = $clog2(MAX_SIDE + 1);
   localparam int CNT_W       = $clog2(MAX_CELLS + 1);
   localparam int PHASE_W     = $clog2(CNT_W + 2);
   localparam logic [CFG_W-1:0] SIDE_RESET = CFG_W'(8);

   typedef logic signed [VALUE_WIDTH-1:0] value_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SORT,
      ST_DRAIN
   } state_type;

   // Broadcast control from the sequencer to the cell array.
   typedef struct packed {
      logic              shift;
      logic              exch;
      logic              parity;
      logic              row_phase;
      logic [SIDE_W-1:0] side;
   } mss_ctl_type;

   // Per-cell control.
   typedef struct packed {
      logic shift;
      logic exch;
      logic keep_min;
   } cell_ctl_type;

   // Clamp the register to 1..MAX_SIDE.
   function automatic logic [SIDE_W-1:0] live_side(input logic [CFG_W-1:0] cfg);
      logic [SIDE_W-1:0] s;
      s = SIDE_W'(cfg);
      if (cfg == '0) begin
         s = SIDE_W'(1);
      end else if (32'(cfg) > MAX_SIDE) begin
         s = SIDE_W'(MAX_SIDE);
      end
      return s;
   endfunction

   // ceil(log2(cells)) + 1
   function automatic logic [PHASE_W-1:0] phase_total(input logic [CNT_W-1:0] cells);
      logic [PHASE_W-1:0] steps;
      steps = '0;
      for (int i = 0; i <= CNT_W; i++) begin
         if ((32'd1 << i) < 32'(cells)) begin
            steps = PHASE_W'(i + 1);
         end
      end
      return steps + PHASE_W'(1);
   endfunction
endpackage
`default_nettype wire

// ===== design/mss_ifs.sv =====
// Channel interfaces: input items, result items, configuration writes.
`default_nettype none
interface mss_req_if import mss_pkg::*; ();
   logic      valid;
   logic      ready;
   value_type element_value;
   modport source (output valid, output element_value, input ready);
   modport sink   (input valid, input element_value, output ready);
endinterface

interface mss_rsp_if import mss_pkg::*; ();
   logic      valid;
   logic      ready;
   value_type sorted_value;
   logic      last_element;
   modport source (output valid, output sorted_value, output last_element, input ready);
   modport sink   (input valid, input sorted_value, input last_element, output ready);
endinterface

interface mss_csr_if import mss_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] mesh_side;
   modport source (output valid, output mesh_side, input ready);
   modport sink   (input valid, input mesh_side, output ready);
endinterface
`default_nettype wire

// ===== design/mesh_shear_sort.sv =====
// Top level: shearsort mesh of compare-exchange cells with a sequencer.
// A mesh of side s is loaded one item a cycle while the sender holds valid,
//   then sorted in P = ceil(log2(s*s)) + 1 phases of s odd-even steps, then
//   drained; the first result shows the cycle after sorting ends.
// The shift chain and the shared sort phases let a new mesh in only after
//   the last one has drained. Reset: load state, empty mesh, side 8.
`default_nettype none
module mesh_shear_sort import mss_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   mss_req_if.sink      req_ch,
   mss_rsp_if.source    rsp_ch,
   mss_csr_if.sink      csr_ch
);
   mss_ctl_type ctl;
   value_type   vals [MAX_SIDE][MAX_SIDE];

   // Config writes are always taken; they restart loading.
   assign csr_ch.ready = 1'b1;

   mss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .rsp_last  (rsp_ch.last_element),
      .csr_valid (csr_ch.valid),
      .csr_data  (csr_ch.mesh_side),
      .ctl       (ctl)
   );

   // Results leave from the head of the row-major chain.
   assign rsp_ch.sorted_value = vals[0][0];

   for (genvar r = 0; r < MAX_SIDE; r++) begin : g_row
      for (genvar c = 0; c < MAX_SIDE; c++) begin : g_col
         localparam int CR = (c < MAX_SIDE - 1) ? c + 1 : c;
         localparam int CL = (c > 0) ? c - 1 : c;
         localparam int RD = (r < MAX_SIDE - 1) ? r + 1 : r;
         localparam int RU = (r > 0) ? r - 1 : r;
         localparam logic PC = 1'(c % 2);
         localparam logic PL = 1'(CL % 2);
         localparam logic PR = 1'(r % 2);
         localparam logic PU = 1'(RU % 2);

         cell_ctl_type cctl;
         value_type    shift_in, partner;
         logic         in_mesh, has_right, has_left, has_down, has_up;
         logic         pair_a, pair_b, asc;

         assign in_mesh   = SIDE_W'(r) < ctl.side && SIDE_W'(c) < ctl.side;
         assign has_right = (c < MAX_SIDE - 1) && SIDE_W'(c + 1) < ctl.side;
         assign has_left  = c > 0;
         assign has_down  = (r < MAX_SIDE - 1) && SIDE_W'(r + 1) < ctl.side;
         assign has_up    = r > 0;
         assign asc       = (r % 2) == 0;

         // Snake-free row-major chain: end of a row feeds from the next row.
         always_comb begin
            if (has_right) begin
               shift_in = vals[r][CR];
            end else if (has_down) begin
               shift_in = vals[RD][0];
            end else begin
               shift_in = req_ch.valid && req_ch.ready ? req_ch.element_value : vals[r][c];
            end
         end

         // Odd-even transposition pairing for the current step.
         always_comb begin
            if (ctl.row_phase) begin
               pair_a = has_right && (PC == ctl.parity);
               pair_b = has_left && (PL == ctl.parity);
               partner = pair_a ? vals[r][CR] : vals[r][CL];
               cctl.keep_min = pair_a ? asc : !asc;
            end else begin
               pair_a = has_down && (PR == ctl.parity);
               pair_b = has_up && (PU == ctl.parity);
               partner = pair_a ? vals[RD][c] : vals[RU][c];
               cctl.keep_min = pair_a;
            end
            cctl.shift = ctl.shift && in_mesh;
            cctl.exch  = ctl.exch && in_mesh && (pair_a || pair_b);
         end

         mss_cell u_cell (
            .clock    (clock),
            .ctl      (cctl),
            .shift_in (shift_in),
            .partner  (partner),
            .value    (vals[r][c])
         );
      end
   end
endmodule
`default_nettype wire

// ===== design/mss_cell.sv =====
// One mesh cell: shift-chain stage plus compare-exchange with a neighbor.
`default_nettype none
module mss_cell import mss_pkg::*; (
   input  wire logic         clock,
   input  cell_ctl_type      ctl,
   input  value_type         shift_in,
   input  value_type         partner,
   output value_type         value
);
   value_type val_ff, val_in;
   logic      lt;

   assign lt = partner < val_ff;

   always_comb begin
      val_in = val_ff;
      if (ctl.shift) begin
         val_in = shift_in;
      end else if (ctl.exch) begin
         if (ctl.keep_min) begin
            val_in = lt ? partner : val_ff;
         end else begin
            val_in = lt ? val_ff : partner;
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   assign value = val_ff;
endmodule
`default_nettype wire

// ===== design/mss_ctrl.sv =====
// Sequencer: load, sort phases, drain; holds the side register.
`default_nettype none
module mss_ctrl import mss_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic                  rsp_last,
   input  wire logic             csr_valid,
   input  wire logic [CFG_W-1:0] csr_data,
   output mss_ctl_type           ctl
);
   `include "mesh_shear_sort_assert.svh"

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [SIDE_W-1:0]  step_ff, step_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [CFG_W-1:0]   side_ff, side_in;
   logic [SIDE_W-1:0]  side;
   logic [CNT_W-1:0]   cells, last_cnt;
   logic [PHASE_W-1:0] ptot;
   logic               req_fire, rsp_fire, step_end, sort_end;

   assign side     = live_side(side_ff);
   assign cells    = CNT_W'(side) * CNT_W'(side);
   assign last_cnt = cells - CNT_W'(1);
   assign ptot     = phase_total(cells);
   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;
   assign step_end = step_ff == side - SIDE_W'(1);
   assign sort_end = step_end && (phase_ff == ptot - PHASE_W'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      if (csr_valid) begin
         state_in = ST_LOAD;
      end else begin
         case (state_ff)
            ST_LOAD: begin
               if (req_fire && count_ff == last_cnt) state_in = ST_SORT;
            end
            ST_SORT: begin
               if (sort_end) state_in = ST_DRAIN;
            end
            ST_DRAIN: begin
               if (rsp_fire && count_ff == last_cnt) state_in = ST_LOAD;
            end
            default: state_in = ST_LOAD;
         endcase
      end
   end

   // counters and side register
   always_comb begin
      side_in  = csr_valid ? csr_data : side_ff;
      count_in = count_ff;
      step_in  = '0;
      phase_in = '0;
      if (csr_valid) begin
         count_in = '0;
      end else if (req_fire || rsp_fire) begin
         count_in = (count_ff == last_cnt) ? '0 : count_ff + CNT_W'(1);
      end
      if (!csr_valid && state_ff == ST_SORT) begin
         step_in  = step_end ? '0 : step_ff + SIDE_W'(1);
         phase_in = step_end ? (sort_end ? '0 : phase_ff + PHASE_W'(1)) : phase_ff;
      end
   end

   // outputs
   always_comb begin
      req_ready     = state_ff == ST_LOAD;
      rsp_valid     = state_ff == ST_DRAIN;
      rsp_last      = (state_ff == ST_DRAIN) && (count_ff == last_cnt);
      ctl.shift     = req_fire || rsp_fire;
      ctl.exch      = state_ff == ST_SORT;
      ctl.parity    = step_ff[0];
      ctl.row_phase = !phase_ff[0];
      ctl.side      = side;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         step_ff  <= '0;
         phase_ff <= '0;
         side_ff  <= SIDE_RESET;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         step_ff  <= step_in;
         phase_ff <= phase_in;
         side_ff  <= side_in;
      end
   end

   `MSS_NEVER(a_ready_and_valid, req_ready && rsp_valid, "load and drain overlap")
   `MSS_ASSERT(a_step_range, (state_ff == ST_SORT) |-> (step_ff < side && phase_ff < ptot), "sort counters out of range")
   `MSS_ASSERT(a_count_range, (state_ff != ST_SORT) |-> (count_ff < cells), "element count out of range")
   `MSS_ASSERT(a_drain_done, (state_ff == ST_DRAIN && rsp_fire && rsp_last && !csr_valid) |=> (state_ff == ST_LOAD && count_ff == '0), "drain did not return to load")
endmodule
`default_nettype wire

// ===== dv/tb_ifs_note.sv =====
// Testbench-side helper types for the shearsort mesh checks.
`timescale 1ns / 1ps
package tb_mss_pkg;
   import mss_pkg::*;
   typedef struct {
      value_type sorted_value;
      logic      last_element;
   } sorted_item_type;
endpackage

// ===== dv/testbench.sv =====
// Testbench for mesh_shear_sort: random and directed meshes checked against a shearsort predictor.
`timescale 1ns / 1ps
module testbench;
   import mss_pkg::*;
   import tb_mss_pkg::*;

   logic clock;
   logic reset;

   mss_req_if req_ch ();
   mss_rsp_if rsp_ch ();
   mss_csr_if csr_ch ();

   mesh_shear_sort DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state: the mesh being loaded and the live register value.
   value_type       mesh_cells [MAX_CELLS];
   int              cells_loaded;
   logic [CFG_W-1:0] side_reg;
   sorted_item_type sorted_queue [$];
   int              error_count;
   bit              sink_hold;   // long receiver hold-off when set
   bit              quiet_mode;  // no random idling on either side

   function automatic int side_in_use();
      if (side_reg == 0) return 1;
      if (int'(side_reg) > MAX_SIDE) return MAX_SIDE;
      return int'(side_reg);
   endfunction

   // Sort one row or column of the mesh in place (stride 1 = row).
   function automatic void sort_line(int first, int stride, int count, bit descending);
      value_type v, p;
      int j;
      for (int i = 1; i < count; i++) begin
         v = mesh_cells[first + i * stride];
         j = i;
         while (j > 0) begin
            p = mesh_cells[first + (j - 1) * stride];
            if (descending ? (p < v) : (v < p)) begin
               mesh_cells[first + j * stride] = p;
               j--;
            end else begin
               break;
            end
         end
         mesh_cells[first + j * stride] = v;
      end
   endfunction

   // Load one element; on a full mesh run shearsort and queue the results.
   function automatic void predict_element(value_type val);
      int s, cells, phases, reach;
      sorted_item_type r;
      s = side_in_use();
      cells = s * s;
      mesh_cells[cells_loaded] = val;
      cells_loaded++;
      if (cells_loaded < cells) return;
      phases = 1;
      reach = 1;
      while (reach < cells) begin
         reach *= 2;
         phases++;
      end
      for (int ph = 0; ph < phases; ph++) begin
         for (int ln = 0; ln < s; ln++) begin
            if (ph % 2 == 0) sort_line(ln * s, 1, s, ln % 2 != 0);
            else sort_line(ln, s, s, 1'b0);
         end
      end
      for (int k = 0; k < cells; k++) begin
         r.sorted_value = mesh_cells[k];
         r.last_element = (k == cells - 1);
         sorted_queue.push_back(r);
      end
      cells_loaded = 0;
   endfunction

   // Send one element, idling at random before it. Valid stays high on
   // return so the next item can follow back to back.
   task automatic send_element(value_type val);
      while (!quiet_mode && $urandom_range(99) < 7) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.element_value <= val;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_element(val);
   endtask

   // Drop valid, then wait for every expected result.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (sorted_queue.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   // Register write: only with the block idle, so drain first.
   task automatic write_side(logic [CFG_W-1:0] s);
      wait_drained();
      csr_ch.valid     <= 1'b1;
      csr_ch.mesh_side <= s;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      side_reg     = s;
      cells_loaded = 0;
   endtask

   function automatic value_type random_value();
      case ($urandom_range(3))
         0: return value_type'($urandom_range(7)) - 4;   // many duplicates
         1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
         default: return value_type'($urandom());
      endcase
   endfunction

   task automatic send_mesh(int count);
      for (int i = 0; i < count; i++) send_element(random_value());
   endtask

   // Receiver: random stalls, plus a long hold-off when asked.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= !sink_hold && (quiet_mode || $urandom_range(99) >= 7);
      end
   end

   // Result checker: compare each accepted item with the oldest expectation.
   always @(posedge clock) begin
      sorted_item_type exp_item;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (sorted_queue.size() == 0) begin
            $error("unexpected result item: sorted_value %0d", rsp_ch.sorted_value);
            error_count++;
         end else begin
            exp_item = sorted_queue.pop_front();
            if (rsp_ch.sorted_value !== exp_item.sorted_value) begin
               $error("sorted_value: expected %0d, actual %0d",
                      exp_item.sorted_value, rsp_ch.sorted_value);
               error_count++;
            end
            if (rsp_ch.last_element !== exp_item.last_element) begin
               $error("last_element: expected %0b, actual %0b",
                      exp_item.last_element, rsp_ch.last_element);
               error_count++;
            end
         end
      end
   end

   // Directed: extremes, single-element mesh, side clamping, all-equal mesh, dropped partial mesh.
   task automatic test_directed();
      write_side(4'd1);
      send_element(32'sh7fffffff);
      send_element(32'sh80000000);
      write_side(4'd0);                     // side of zero acts as one
      send_element(32'sh0);
      send_element(-32'sd1);
      write_side(4'd2);
      send_element(32'sh7fffffff);
      send_element(32'sh80000000);
      send_element(32'sh55555555);
      send_element(32'shaaaaaaaa);
      write_side(4'd3);                     // all equal values
      repeat (9) send_element(32'sd7);
      write_side(4'd2);
      send_element(32'sd1);                 // partial mesh dropped by the write
      write_side(4'd2);
      send_element(32'sd4);
      send_element(32'sd3);
      send_element(32'sd2);
      send_element(32'sd1);
   endtask

   // Random meshes over small sides, one mid-size one.
   task automatic test_random_meshes();
      int s;
      for (int m = 0; m < 9; m++) begin
         s = (m == 8) ? $urandom_range(5, 6) : $urandom_range(1, 4);
         write_side(4'(s));
         send_mesh(s * s);
      end
   endtask

   // Sides above the maximum act as the maximum.
   task automatic test_oversize_side();
      write_side(4'd15);
      send_mesh(MAX_CELLS);
   endtask

   // Receiver holds off long while the sender keeps offering the next mesh.
   task automatic test_backpressure();
      write_side(4'd3);
      fork
         begin
            sink_hold = 1'b1;
            repeat (300) @(posedge clock);
            sink_hold = 1'b0;
         end
         send_mesh(27);
      join
      wait_drained();                       // sender pauses until all results are in
      quiet_mode = 1'b1;                    // stretch with no idling
      send_mesh(9);
      quiet_mode = 1'b0;
   endtask

   initial begin
      reset        = 1'b1;
      clock        = 1'b0;
      error_count  = 0;
      sink_hold    = 1'b0;
      quiet_mode   = 1'b0;
      side_reg     = SIDE_RESET;
      cells_loaded = 0;
      req_ch.valid         <= 1'b0;
      req_ch.element_value <= '0;
      csr_ch.valid         <= 1'b0;
      csr_ch.mesh_side     <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_meshes();
      test_oversize_side();
      test_backpressure();
      wait_drained();
      if (error_count == 0 && sorted_queue.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("tb: failure");
      $finish;
   end
endmodule
